@@ sv/reclaim_latency_histogram_macros.svh @@
// Assertion macros shared by the histogram RTL.
`ifndef RECLAIM_LATENCY_HISTOGRAM_MACROS_SVH
`define RECLAIM_LATENCY_HISTOGRAM_MACROS_SVH
`ifndef ASSERT_OFF
`define RLH_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("reclaim_latency_histogram: assertion failed");
`define RLH_ASSERT_NEVER(label, cond) `RLH_ASSERT(label, !(cond))
`else
`define RLH_ASSERT(label, prop)
`define RLH_ASSERT_NEVER(label, cond)
`endif
`endif

@@ sv/rlh_pkg.sv @@
package rlh_pkg;
	localparam int SCORE_W      = 11;
	localparam int LAT_W        = 31;
	localparam int THR_W        = 63;
	localparam int THR_FIELD_W  = 21;
	localparam int NUM_CLASSES  = 4;
	localparam int NUM_BINS     = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int IN_TDATA_W   = 48;
	localparam int OUT_TDATA_W  = 216;
	localparam int OUT_COUNT_W  = 32;
	localparam int OUT_TIME_W   = 48;
	localparam int EXT_W        = 64;

	localparam logic [THR_W-1:0] THR_RESET = 63'd2199023360409605;
	localparam logic signed [SCORE_W-1:0] SCORE_VISIBLE_MAX = 11'sd200;

	typedef logic [1:0] class_t;
	typedef logic [1:0] bin_t;

	localparam class_t CLASS_NATIVE  = 2'd0;
	localparam class_t CLASS_TOP     = 2'd1;
	localparam class_t CLASS_VISIBLE = 2'd2;
	localparam class_t CLASS_OTHER   = 2'd3;

	localparam bin_t BIN_LOW     = 2'd0;
	localparam bin_t BIN_MID     = 2'd1;
	localparam bin_t BIN_HIGH    = 2'd2;
	localparam bin_t BIN_EXTREME = 2'd3;

	typedef logic [NUM_CLASSES-1:0][THR_W-1:0] thr_bank_t;

	typedef struct packed {
		class_t cls;
		bin_t   bin;
	} sel_t;
endpackage

@@ sv/rlh_ram.sv @@
module rlh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ sv/rlh_classify.sv @@
module rlh_classify (
	input  logic signed [rlh_pkg::SCORE_W-1:0] score_adj,
	input  logic [rlh_pkg::LAT_W-1:0]          latency_ms,
	input  rlh_pkg::thr_bank_t                 thr_bank,
	output rlh_pkg::sel_t                      sel
);
	logic [rlh_pkg::THR_W-1:0]       thr;
	logic [rlh_pkg::THR_FIELD_W-1:0] thr_low;
	logic [rlh_pkg::THR_FIELD_W-1:0] thr_mid;
	logic [rlh_pkg::THR_FIELD_W-1:0] thr_high;

	always_comb begin
		if (score_adj[rlh_pkg::SCORE_W-1]) begin
			sel.cls = rlh_pkg::CLASS_NATIVE;
		end else if (score_adj == '0) begin
			sel.cls = rlh_pkg::CLASS_TOP;
		end else if (score_adj <= rlh_pkg::SCORE_VISIBLE_MAX) begin
			sel.cls = rlh_pkg::CLASS_VISIBLE;
		end else begin
			sel.cls = rlh_pkg::CLASS_OTHER;
		end

		thr      = thr_bank[sel.cls];
		thr_low  = thr[rlh_pkg::THR_FIELD_W-1:0];
		thr_mid  = thr[2*rlh_pkg::THR_FIELD_W-1:rlh_pkg::THR_FIELD_W];
		thr_high = thr[3*rlh_pkg::THR_FIELD_W-1:2*rlh_pkg::THR_FIELD_W];

		// The first threshold that the latency lies below decides the bin.
		if (latency_ms < rlh_pkg::LAT_W'(thr_low)) begin
			sel.bin = rlh_pkg::BIN_LOW;
		end else if (latency_ms < rlh_pkg::LAT_W'(thr_mid)) begin
			sel.bin = rlh_pkg::BIN_MID;
		end else if (latency_ms < rlh_pkg::LAT_W'(thr_high)) begin
			sel.bin = rlh_pkg::BIN_HIGH;
		end else begin
			sel.bin = rlh_pkg::BIN_EXTREME;
		end
	end
endmodule

@@ sv/reclaim_latency_histogram.sv @@
// Channel   | Direction | Fields, lowest bit first
// s_axis    | in        | tdata: score_adj[10:0], latency_ms[41:11], zero fill to 48 bits
// m_axis    | out       | tdata: class_index, bin_index, count_low, count_mid, count_high,
//           |           |        count_extreme, event_total, time_total, zero fill to 216 bits
// cfg       | in        | cfg_index selects the class whose thresholds cfg_data replaces
//
// One item per cycle unless the output stalls; an item passes the s1 and output registers.
// The class row is read from the state memory when the item is accepted, updated and
// written back as the item leaves s1; the row just written is forwarded to a following item.
// Reset marks every row as empty, so no clearing pass is needed.
// A stalled output holds one result and one item in flight; input is refused only then.
`include "reclaim_latency_histogram_macros.svh"

module reclaim_latency_histogram #(
	parameter int COUNT_WIDTH = 32,
	parameter int TIME_WIDTH  = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// score_adj, latency_ms
	input  logic [rlh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// class_index, bin_index, count_low, count_mid, count_high, count_extreme,
	// event_total, time_total
	output logic [rlh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [rlh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rlh_pkg::THR_W-1:0]          cfg_data
);
	localparam int ROW_W  = rlh_pkg::NUM_BINS * COUNT_WIDTH + COUNT_WIDTH + TIME_WIDTH;
	localparam int EVT_LO = rlh_pkg::NUM_BINS * COUNT_WIDTH;
	localparam int TIME_LO = EVT_LO + COUNT_WIDTH;
	localparam int SUM_W  = ((TIME_WIDTH > rlh_pkg::LAT_W) ? TIME_WIDTH : rlh_pkg::LAT_W) + 1;

	rlh_pkg::thr_bank_t                thr_q;
	logic signed [rlh_pkg::SCORE_W-1:0] in_score;
	logic [rlh_pkg::LAT_W-1:0]         in_lat;
	rlh_pkg::sel_t                     in_sel;
	logic                              acc_in;
	logic                              adv1;
	logic                              wr_en;

	logic                              s1_vld_q;
	rlh_pkg::sel_t                     sel_s1;
	logic [rlh_pkg::LAT_W-1:0]         lat_s1;

	logic [ROW_W-1:0]                  ram_rdata;
	logic [ROW_W-1:0]                  cur_row;
	logic [ROW_W-1:0]                  new_row;
	logic [rlh_pkg::NUM_CLASSES-1:0]   row_vld_q;
	logic                              byp_vld_q;

	logic [COUNT_WIDTH-1:0]            cur_cnt;
	logic [COUNT_WIDTH-1:0]            cur_evt;
	logic [COUNT_WIDTH-1:0]            new_evt;
	logic [TIME_WIDTH-1:0]             cur_time;
	logic [SUM_W-1:0]                  sum_ext;

	logic                              out_vld_q;
	rlh_pkg::sel_t                     out_sel_q;
	logic [ROW_W-1:0]                  out_row_q;
	logic [rlh_pkg::NUM_BINS-1:0][rlh_pkg::OUT_COUNT_W-1:0] out_cnt;
	logic [rlh_pkg::OUT_COUNT_W-1:0]   out_evt;
	logic [rlh_pkg::OUT_TIME_W-1:0]    out_time;
	logic [COUNT_WIDTH-1:0]            out_bin_cnt;

	assign in_score = s_axis_tdata[rlh_pkg::SCORE_W-1:0];
	assign in_lat   = s_axis_tdata[rlh_pkg::SCORE_W+rlh_pkg::LAT_W-1:rlh_pkg::SCORE_W];

	assign adv1          = !out_vld_q || m_axis_tready;
	assign s_axis_tready = !s1_vld_q || adv1;
	assign acc_in        = s_axis_tvalid && s_axis_tready;
	assign wr_en         = s1_vld_q && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < rlh_pkg::NUM_CLASSES; c++) begin
				thr_q[c] <= rlh_pkg::THR_RESET;
			end
		end else if (cfg_we) begin
			thr_q[cfg_index] <= cfg_data;
		end
	end

	rlh_classify u_classify (
		.score_adj  (in_score),
		.latency_ms (in_lat),
		.thr_bank   (thr_q),
		.sel        (in_sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_vld_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			sel_s1 <= in_sel;
			lat_s1 <= in_lat;
		end
	end

	rlh_ram #(
		.WIDTH (ROW_W),
		.DEPTH (rlh_pkg::NUM_CLASSES)
	) u_row_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (sel_s1.cls),
		.wdata (new_row),
		.re    (acc_in),
		.raddr (in_sel.cls),
		.rdata (ram_rdata)
	);

	// The output register also holds the row last written, which the memory read misses
	// when the same class was written at the edge of the read.
	always_comb begin
		if (byp_vld_q && out_sel_q.cls == sel_s1.cls) begin
			cur_row = out_row_q;
		end else if (row_vld_q[sel_s1.cls]) begin
			cur_row = ram_rdata;
		end else begin
			cur_row = '0;
		end

		new_row = cur_row;
		for (int b = 0; b < rlh_pkg::NUM_BINS; b++) begin
			cur_cnt = cur_row[b*COUNT_WIDTH +: COUNT_WIDTH];
			if (sel_s1.bin == rlh_pkg::bin_t'(b) && cur_cnt != '1) begin
				new_row[b*COUNT_WIDTH +: COUNT_WIDTH] = cur_cnt + 1'b1;
			end
		end

		cur_evt = cur_row[EVT_LO +: COUNT_WIDTH];
		new_evt = (cur_evt == '1) ? cur_evt : cur_evt + 1'b1;
		new_row[EVT_LO +: COUNT_WIDTH] = new_evt;

		cur_time = cur_row[TIME_LO +: TIME_WIDTH];
		sum_ext  = SUM_W'(cur_time) + SUM_W'(lat_s1);
		if (sum_ext > SUM_W'({TIME_WIDTH{1'b1}})) begin
			new_row[TIME_LO +: TIME_WIDTH] = '1;
		end else begin
			new_row[TIME_LO +: TIME_WIDTH] = sum_ext[TIME_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			byp_vld_q <= 1'b0;
			row_vld_q <= '0;
		end else begin
			if (adv1) begin
				out_vld_q <= s1_vld_q;
			end
			if (wr_en) begin
				byp_vld_q <= 1'b1;
				row_vld_q[sel_s1.cls] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_sel_q <= sel_s1;
			out_row_q <= new_row;
		end
	end

	always_comb begin
		for (int b = 0; b < rlh_pkg::NUM_BINS; b++) begin
			out_cnt[b] = rlh_pkg::OUT_COUNT_W'(
				rlh_pkg::EXT_W'(out_row_q[b*COUNT_WIDTH +: COUNT_WIDTH]));
		end
	end

	assign out_evt  = rlh_pkg::OUT_COUNT_W'(rlh_pkg::EXT_W'(out_row_q[EVT_LO +: COUNT_WIDTH]));
	assign out_time = rlh_pkg::OUT_TIME_W'(rlh_pkg::EXT_W'(out_row_q[TIME_LO +: TIME_WIDTH]));
	assign out_bin_cnt = out_row_q[out_sel_q.bin*COUNT_WIDTH +: COUNT_WIDTH];

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {4'b0000, out_time, out_evt,
		out_cnt[3], out_cnt[2], out_cnt[1], out_cnt[0],
		out_sel_q.bin, out_sel_q.cls};

	`RLH_ASSERT(a_accept_fills_s1, acc_in |=> s1_vld_q)
	`RLH_ASSERT(a_result_from_s1, $rose(m_axis_tvalid) |-> $past(s1_vld_q))
	`RLH_ASSERT(a_row_marked, wr_en |=> row_vld_q[$past(sel_s1.cls)])
	`RLH_ASSERT(a_event_count_nonzero, wr_en |-> new_evt != '0)
	`RLH_ASSERT_NEVER(a_bin_above_total, m_axis_tvalid && out_bin_cnt > out_row_q[EVT_LO +: COUNT_WIDTH])
endmodule

@@ tb/sv/reclaim_latency_histogram_checker.sv @@
module reclaim_latency_histogram_checker
	import rlh_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// score_adj, latency_ms
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// class_index, bin_index, count_low, count_mid, count_high, count_extreme,
	// event_total, time_total
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [THR_W-1:0]       cfg_data,
	output int unsigned            mismatches,
	output int unsigned            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_FIELDS = 8;
	localparam int SHOW_LIMIT = 10;

	typedef logic [NUM_FIELDS-1:0][OUT_TIME_W-1:0] report_t;

	thr_bank_t             thr_regs;
	logic [OUT_COUNT_W-1:0] bin_count [NUM_CLASSES][NUM_BINS];
	logic [OUT_COUNT_W-1:0] class_events [NUM_CLASSES];
	logic [OUT_TIME_W-1:0]  class_time [NUM_CLASSES];
	report_t               awaited_reports [$];
	int unsigned           fail_total;

	function automatic int field_width(input int i);
		if (i < 2) begin
			return 2;
		end
		return (i == NUM_FIELDS - 1) ? OUT_TIME_W : OUT_COUNT_W;
	endfunction

	function automatic string field_name(input int i);
		case (i)
			0: return "class_index";
			1: return "bin_index";
			2: return "count_low";
			3: return "count_mid";
			4: return "count_high";
			5: return "count_extreme";
			6: return "event_total";
			default: return "time_total";
		endcase
	endfunction

	function automatic report_t split_report(input logic [OUT_TDATA_W-1:0] word);
		report_t r;
		int lsb;
		lsb = 0;
		for (int i = 0; i < NUM_FIELDS; i++) begin
			r[i] = OUT_TIME_W'((word >> lsb) & ((OUT_TDATA_W'(1) << field_width(i)) - 1'b1));
			lsb += field_width(i);
		end
		return r;
	endfunction

	function automatic class_t classify_score(input logic signed [SCORE_W-1:0] score);
		if (score < 0) begin
			return CLASS_NATIVE;
		end else if (score == 0) begin
			return CLASS_TOP;
		end else if (score <= SCORE_VISIBLE_MAX) begin
			return CLASS_VISIBLE;
		end
		return CLASS_OTHER;
	endfunction

	function automatic bin_t bin_for_latency(input logic [THR_W-1:0] thr,
			input logic [LAT_W-1:0] lat);
		if (lat < thr[0 +: THR_FIELD_W]) begin
			return BIN_LOW;
		end else if (lat < thr[THR_FIELD_W +: THR_FIELD_W]) begin
			return BIN_MID;
		end else if (lat < thr[2 * THR_FIELD_W +: THR_FIELD_W]) begin
			return BIN_HIGH;
		end
		return BIN_EXTREME;
	endfunction

	function automatic logic [OUT_COUNT_W-1:0] sat_bump(input logic [OUT_COUNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		report_t got;
		report_t want;
		class_t cls;
		bin_t bin_sel;
		logic [LAT_W-1:0] lat;
		logic [OUT_TIME_W:0] sum;
		if (!arst_n) begin
			thr_regs = {NUM_CLASSES{THR_RESET}};
			for (int c = 0; c < NUM_CLASSES; c++) begin
				class_events[c] = '0;
				class_time[c] = '0;
				for (int b = 0; b < NUM_BINS; b++) begin
					bin_count[c][b] = '0;
				end
			end
			awaited_reports.delete();
			fail_total = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				thr_regs[cfg_index] = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = split_report(m_axis_tdata);
				if (awaited_reports.size() == 0) begin
					fail_total++;
					if (fail_total <= SHOW_LIMIT) begin
						$display("%0t: result with no item outstanding, data %0h", $realtime,
							m_axis_tdata);
					end
				end else begin
					want = awaited_reports.pop_front();
					for (int i = 0; i < NUM_FIELDS; i++) begin
						if (got[i] !== want[i]) begin
							fail_total++;
							if (fail_total <= SHOW_LIMIT) begin
								$display("%0t: %s expected %0h, got %0h", $realtime,
									field_name(i), want[i], got[i]);
							end
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				lat = s_axis_tdata[SCORE_W +: LAT_W];
				cls = classify_score($signed(s_axis_tdata[SCORE_W-1:0]));
				bin_sel = bin_for_latency(thr_regs[cls], lat);
				bin_count[cls][bin_sel] = sat_bump(bin_count[cls][bin_sel]);
				class_events[cls] = sat_bump(class_events[cls]);
				sum = {1'b0, class_time[cls]} + lat;
				class_time[cls] = sum[OUT_TIME_W] ? '1 : sum[OUT_TIME_W-1:0];
				want = '0;
				want[0] = OUT_TIME_W'(cls);
				want[1] = OUT_TIME_W'(bin_sel);
				for (int b = 0; b < NUM_BINS; b++) begin
					want[2 + b] = OUT_TIME_W'(bin_count[cls][b]);
				end
				want[6] = OUT_TIME_W'(class_events[cls]);
				want[7] = class_time[cls];
				awaited_reports.push_back(want);
			end
			mismatches <= fail_total;
			pending <= awaited_reports.size();
		end
	end
endmodule

@@ tb/sv/tb_reclaim_latency_histogram.sv @@
module tb_reclaim_latency_histogram;
	timeunit 1ns;
	timeprecision 1ps;

	import rlh_pkg::*;

	localparam int          PHASE_ITEMS    = 200;
	localparam int          RANDOM_PHASES  = 8;
	localparam int          RUSH_ITEMS     = 64;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned STALL_LIMIT    = 5000;
	localparam int          SETTLE_CYCLES  = 4;
	localparam logic [LAT_W-1:0] LAT_MAX   = '1;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_PATTERN,
		RX_RANDOM
	} rx_style_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [THR_W-1:0]       cfg_data = '0;

	int unsigned fail_count;
	int unsigned outstanding;

	rx_style_t   rx_style = RX_RANDOM;
	logic [7:0]  hold_seq = '0;
	logic [7:0]  hold_seen = '0;
	int unsigned hold_left = 0;
	int unsigned rx_tick = 0;
	int unsigned quiet_cycles = 0;

	bit          idle_on = 1'b1;
	int          burst_left = 0;
	thr_bank_t   thr_now = {NUM_CLASSES{THR_RESET}};

	reclaim_latency_histogram u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	reclaim_latency_histogram_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (fail_count),
		.pending       (outstanding)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_style)
				RX_PATTERN: m_axis_tready <= (rx_tick % 11) < 6;
				RX_RANDOM:  m_axis_tready <= $urandom_range(0, 2) != 0;
				default:    m_axis_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [THR_W-1:0] pack_thr(input logic [THR_FIELD_W-1:0] lo,
			input logic [THR_FIELD_W-1:0] mid, input logic [THR_FIELD_W-1:0] hi);
		return {hi, mid, lo};
	endfunction

	function automatic logic [THR_FIELD_W-1:0] rand_field();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return THR_FIELD_W'($urandom_range(0, 2000));
			default: return THR_FIELD_W'($urandom);
		endcase
	endfunction

	function automatic thr_bank_t random_thresholds();
		thr_bank_t bank;
		int unsigned lo;
		int unsigned mid;
		int unsigned hi;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			lo = $urandom_range(0, 100);
			mid = lo + $urandom_range(0, 1000);
			hi = mid + $urandom_range(0, 10000);
			case ($urandom_range(0, 3))
				0, 1: bank[c] = pack_thr(THR_FIELD_W'(lo), THR_FIELD_W'(mid),
					THR_FIELD_W'(hi));
				2: bank[c] = THR_W'({$urandom, $urandom});
				default: bank[c] = pack_thr(rand_field(), rand_field(), rand_field());
			endcase
		end
		return bank;
	endfunction

	function automatic int score_for(input class_t c);
		case (c)
			CLASS_NATIVE: begin
				case ($urandom_range(0, 3))
					0: return -1;
					1: return -1000;
					default: return -int'($urandom_range(1, 1000));
				endcase
			end
			CLASS_TOP: return 0;
			CLASS_VISIBLE: begin
				case ($urandom_range(0, 2))
					0: return 1;
					1: return 200;
					default: return int'($urandom_range(1, 200));
				endcase
			end
			default: begin
				case ($urandom_range(0, 2))
					0: return 201;
					1: return 1000;
					default: return int'($urandom_range(201, 1000));
				endcase
			end
		endcase
	endfunction

	function automatic logic [LAT_W-1:0] latency_for(input class_t c);
		logic [THR_FIELD_W-1:0] thr_pt;
		thr_pt = thr_now[c][THR_FIELD_W * $urandom_range(0, 2) +: THR_FIELD_W];
		case ($urandom_range(0, 9))
			0, 1: return LAT_W'(thr_pt) - LAT_W'(thr_pt != 0);
			2, 3: return LAT_W'(thr_pt);
			4: return LAT_W'(thr_pt) + 1'b1;
			5, 6: return LAT_W'($urandom_range(0, 1 << THR_FIELD_W));
			7: return LAT_W'($urandom);
			8: return '0;
			default: return LAT_MAX;
		endcase
	endfunction

	task automatic send_event(input int score, input logic [LAT_W-1:0] lat);
		s_axis_tdata <= IN_TDATA_W'({lat, SCORE_W'(score)});
		s_axis_tvalid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		if (idle_on) begin
			if (burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(0, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_random();
		class_t c;
		c = class_t'($urandom_range(0, NUM_CLASSES - 1));
		send_event(score_for(c), latency_for(c));
	endtask

	// Stops offering items and waits until every outstanding result has left the block.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_thresholds(input thr_bank_t bank);
		for (int i = 0; i < NUM_CLASSES; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= bank[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		thr_now = bank;
	endtask

	initial begin
		thr_bank_t bank;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(0, 24);

		send_event(-1000, 0);
		send_event(-1, 4);
		send_event(0, 5);
		send_event(1, 49);
		send_event(200, 50);
		send_event(201, 499);
		send_event(1000, 500);
		send_event(0, LAT_MAX);
		send_event(-1, LAT_MAX);

		settle();
		bank[CLASS_NATIVE] = '1;
		bank[CLASS_TOP] = '0;
		bank[CLASS_VISIBLE] = pack_thr(1000, 10, 100000);
		bank[CLASS_OTHER] = pack_thr(7, 7, 9);
		load_thresholds(bank);
		send_event(-500, 2097150);
		send_event(-2, 2097151);
		send_event(0, 0);
		send_event(0, 123);
		send_event(150, 5);
		send_event(150, 1000);
		send_event(150, 100000);
		send_event(999, 7);
		send_event(999, 9);
		send_event(300, 6);

		// Offer items back to back with the receiver always ready.
		settle();
		rx_style <= RX_ALWAYS;
		idle_on = 1'b0;
		repeat (RUSH_ITEMS) send_event(1000, LAT_MAX);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			load_thresholds(random_thresholds());
			rx_style <= rx_style_t'(ph % 3);
			idle_on = !((ph % 4) == 1 || ph == 2);
			if (ph == 2) begin
				hold_seq <= hold_seq + 1'b1;
			end
			repeat (PHASE_ITEMS) send_random();
		end

		settle();
		if (fail_count == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
